// File: src/lcsa_pkg.sv
// Shared types, constants and codes for the load cell scale averager.
package lcsa_pkg;

	// Moving average window; must be a power of two so the average is a shift
	localparam int WINDOW = 16;
	localparam int WIN_LOG = $clog2(WINDOW);
	localparam int IDX_W = (WIN_LOG > 0) ? WIN_LOG : 1;

	// Field widths
	localparam int SAMPLE_W = 23;
	localparam int WORD_W = 24;
	localparam int KIND_W = 2;
	localparam int WEIGHT_W = 32;
	localparam int RECIP_W = 32;
	localparam int SUM_W = SAMPLE_W + WIN_LOG;
	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int PROD_W = DIFF_W + RECIP_W;
	localparam int FRAC_SHIFT = 16;

	// Tare counts this many samples and timeouts before capturing the next average
	localparam int TARE_SAMPLES = 3 * WINDOW;
	localparam int TCNT_W = $clog2(TARE_SAMPLES + 1);

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Configuration port
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_RECIP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESET_OFFSET = 1'b1;
	localparam logic [RECIP_W-1:0] CAL_RECIP_RESET = 32'h0100_0000;

	// Input item kinds
	localparam logic [KIND_W-1:0] KIND_READ = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TARE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;

	// Classified operations passed to the back end
	typedef enum logic [1:0] {
		OP_SAMPLE,
		OP_TARE,
		OP_TIMEOUT
	} op_kind_t;

	typedef struct packed {
		op_kind_t kind;
		logic [SAMPLE_W-1:0] sample;
	} op_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [WORD_W-1:0] adc_word;
	} in_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] average;
		logic [WEIGHT_W-1:0] weight;
		logic timed_out;
		logic tare_busy;
		logic tare_captured;
	} out_item_t;

endpackage

// File: src/load_cell_scale_averager_unit.sv
// An accepted item goes through the queue, the back-end stage registers and the output register.
// Throughput: one item per cycle while the output is not stalled, set by the running sum update.
// Items that give no result (not-ready words, tare requests) still use one queue slot or none.
// Reset: asynchronous, clears the sample ring, running sum, tare state and captured offset,
// and loads the calibration registers with their defaults; no clearing pass is needed.
module load_cell_scale_averager_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lcsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lcsa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  lcsa_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output lcsa_pkg::out_item_t             out_data
);

	logic q_full;
	logic q_push;
	lcsa_pkg::op_t push_op;
	logic head_valid;
	logic head_stall;
	lcsa_pkg::op_t head_op;

	// Classify incoming items
	lcsa_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (q_push),
		.op       (push_op)
	);

	// Decoupling queue
	lcsa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_op    (push_op),
		.full       (q_full),
		.head_valid (head_valid),
		.head_stall (head_stall),
		.head_op    (head_op)
	);

	// Averaging, tare and scaling
	lcsa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.op_valid  (head_valid),
		.op_stall  (head_stall),
		.op        (head_op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

`ifndef SYNTH
	// A result cannot be both counting and capturing
	a_busy_capt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.tare_busy && out_data.tare_captured))
		else $error("tare busy and captured on one result");

	// Timeout results carry no average and no weight
	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.timed_out) |-> (out_data.average == '0 && out_data.weight == '0))
		else $error("timeout result with nonzero payload");

	// The front never writes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue overflow");
`endif

endmodule

// File: src/lcsa_front.sv
// Front end: accepts input items, drops not-ready words and unknown kinds, classifies the rest.
module lcsa_front (
	input  logic               in_valid,
	output logic               in_stall,
	input  lcsa_pkg::in_item_t in_data,
	input  logic               q_full,
	output logic               push,
	output lcsa_pkg::op_t      op
);

	logic keep;

	// Decode item kind; not-ready words and unknown kinds carry no work
	always_comb begin
		keep = 1'b0;
		op.kind = lcsa_pkg::OP_SAMPLE;
		op.sample = in_data.adc_word[lcsa_pkg::WORD_W-1:1];
		unique case (in_data.kind)
			lcsa_pkg::KIND_READ: begin
				keep = in_data.adc_word[0];
				op.kind = lcsa_pkg::OP_SAMPLE;
			end
			lcsa_pkg::KIND_TARE: begin
				keep = 1'b1;
				op.kind = lcsa_pkg::OP_TARE;
			end
			lcsa_pkg::KIND_TIMEOUT: begin
				keep = 1'b1;
				op.kind = lcsa_pkg::OP_TIMEOUT;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// Stall only on a full queue; dropped items are still taken
	assign in_stall = q_full;
	assign push = in_valid && !q_full && keep;

endmodule

// File: src/lcsa_queue.sv
// Short queue of classified operations between front and back.
module lcsa_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lcsa_pkg::op_t push_op,
	output logic          full,
	output logic          head_valid,
	input  logic          head_stall,
	output lcsa_pkg::op_t head_op
);

	lcsa_pkg::op_t mem_q [lcsa_pkg::QUEUE_DEPTH];
	logic [lcsa_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [lcsa_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [lcsa_pkg::QCNT_W-1:0] count_q;
	logic pop;

	assign full = (count_q == lcsa_pkg::QCNT_W'(lcsa_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_op = mem_q[rd_ptr_q];
	assign pop = head_valid && !head_stall;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == lcsa_pkg::QPTR_W'(lcsa_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == lcsa_pkg::QPTR_W'(lcsa_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/lcsa_back.sv
// Back end: window ring and running sum, tare sequencing, offset and weight scaling.
module lcsa_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lcsa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lcsa_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                op_valid,
	output logic                                op_stall,
	input  lcsa_pkg::op_t                       op,
	output logic                                out_valid,
	input  logic                                out_stall,
	output lcsa_pkg::out_item_t                 out_data
);

	// Configuration registers
	logic signed [lcsa_pkg::RECIP_W-1:0] cal_recip_q;
	logic [lcsa_pkg::SAMPLE_W-1:0] preset_offset_q;

	// Window state
	logic [lcsa_pkg::SAMPLE_W-1:0] ring_q [lcsa_pkg::WINDOW];
	logic [lcsa_pkg::SUM_W-1:0] sum_q;
	logic [lcsa_pkg::IDX_W-1:0] idx_q;

	// Tare state
	logic [lcsa_pkg::TCNT_W-1:0] tare_count_q;
	logic tare_active_q;
	logic [lcsa_pkg::SAMPLE_W-1:0] captured_offset_q;
	logic offset_captured_q;

	// Stage 1: average and offset
	logic valid_s1;
	logic [lcsa_pkg::SAMPLE_W-1:0] avg_s1;
	logic [lcsa_pkg::SAMPLE_W-1:0] off_s1;
	logic timed_s1, busy_s1, capt_s1;

	// Stage 2: signed difference
	logic valid_s2;
	logic [lcsa_pkg::SAMPLE_W-1:0] avg_s2;
	logic signed [lcsa_pkg::DIFF_W-1:0] diff_s2;
	logic timed_s2, busy_s2, capt_s2;

	// Stage 3: product
	logic valid_s3;
	logic [lcsa_pkg::SAMPLE_W-1:0] avg_s3;
	logic signed [lcsa_pkg::PROD_W-1:0] prod_s3;
	logic timed_s3, busy_s3, capt_s3;

	// Output register
	logic out_valid_q;
	lcsa_pkg::out_item_t out_q;

	logic ready_out, ready_s3, ready_s2, ready_s1;
	logic take;
	logic is_sample, is_timeout, is_tare;
	logic [lcsa_pkg::SUM_W-1:0] sum_next;
	logic [lcsa_pkg::SAMPLE_W-1:0] avg_new;
	logic capture_now, busy_now;
	logic [lcsa_pkg::SAMPLE_W-1:0] off_new;
	logic [lcsa_pkg::WEIGHT_W-1:0] weight_out;

	// Per-stage flow control
	assign ready_out = !out_valid_q || !out_stall;
	assign ready_s3 = !valid_s3 || ready_out;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign op_stall = !ready_s1;
	assign take = op_valid && ready_s1;

	assign is_sample = (op.kind == lcsa_pkg::OP_SAMPLE);
	assign is_timeout = (op.kind == lcsa_pkg::OP_TIMEOUT);
	assign is_tare = (op.kind == lcsa_pkg::OP_TARE);

	// Running sum update and new average
	always_comb begin
		sum_next = sum_q - lcsa_pkg::SUM_W'(ring_q[idx_q])
			+ lcsa_pkg::SUM_W'(op.sample);
		avg_new = is_sample ? sum_next[lcsa_pkg::SUM_W-1:lcsa_pkg::WIN_LOG] : '0;
	end

	// Tare decision and offset in force for this item
	always_comb begin
		busy_now = tare_active_q && (tare_count_q < lcsa_pkg::TCNT_W'(lcsa_pkg::TARE_SAMPLES));
		capture_now = tare_active_q && !busy_now;
		if (capture_now) begin
			off_new = avg_new;
		end else if (offset_captured_q) begin
			off_new = captured_offset_q;
		end else begin
			off_new = preset_offset_q;
		end
	end

	// Configuration, window and tare state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_recip_q <= lcsa_pkg::CAL_RECIP_RESET;
			preset_offset_q <= '0;
			for (int i = 0; i < lcsa_pkg::WINDOW; i++) begin
				ring_q[i] <= '0;
			end
			sum_q <= '0;
			idx_q <= '0;
			tare_count_q <= '0;
			tare_active_q <= 1'b0;
			captured_offset_q <= '0;
			offset_captured_q <= 1'b0;
		end else begin
			if (take && is_sample) begin
				ring_q[idx_q] <= op.sample;
				sum_q <= sum_next;
				idx_q <= (idx_q == lcsa_pkg::IDX_W'(lcsa_pkg::WINDOW - 1))
					? '0 : idx_q + 1'b1;
			end
			if (take && is_tare) begin
				tare_active_q <= 1'b1;
				tare_count_q <= '0;
			end else if (take && (is_sample || is_timeout)) begin
				if (busy_now) begin
					tare_count_q <= tare_count_q + 1'b1;
				end else if (capture_now) begin
					captured_offset_q <= avg_new;
					offset_captured_q <= 1'b1;
					tare_active_q <= 1'b0;
					tare_count_q <= '0;
				end
			end
			if (cfg_we) begin
				unique case (cfg_index)
					lcsa_pkg::REG_CAL_RECIP: begin
						cal_recip_q <= cfg_data;
					end
					lcsa_pkg::REG_PRESET_OFFSET: begin
						preset_offset_q <= cfg_data[lcsa_pkg::SAMPLE_W-1:0];
						offset_captured_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= take && !is_tare;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_out) out_valid_q <= valid_s3;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (ready_s1) begin
			avg_s1 <= avg_new;
			off_s1 <= off_new;
			timed_s1 <= is_timeout;
			busy_s1 <= busy_now;
			capt_s1 <= capture_now;
		end
	end

	// Stage 2: difference against offset
	always_ff @(posedge clk) begin
		if (ready_s2) begin
			avg_s2 <= avg_s1;
			diff_s2 <= $signed({1'b0, avg_s1}) - $signed({1'b0, off_s1});
			timed_s2 <= timed_s1;
			busy_s2 <= busy_s1;
			capt_s2 <= capt_s1;
		end
	end

	// Stage 3: scale by reciprocal
	always_ff @(posedge clk) begin
		if (ready_s3) begin
			avg_s3 <= avg_s2;
			prod_s3 <= lcsa_pkg::PROD_W'(diff_s2) * lcsa_pkg::PROD_W'(cal_recip_q);
			timed_s3 <= timed_s2;
			busy_s3 <= busy_s2;
			capt_s3 <= capt_s2;
		end
	end

	// Zero on a timeout, clamp at zero, drop fraction bits, saturate high
	always_comb begin
		if (timed_s3 || prod_s3[lcsa_pkg::PROD_W-1] || (prod_s3 == '0)) begin
			weight_out = '0;
		end else if (|prod_s3[lcsa_pkg::PROD_W-2:lcsa_pkg::FRAC_SHIFT+lcsa_pkg::WEIGHT_W]) begin
			weight_out = '1;
		end else begin
			weight_out = prod_s3[lcsa_pkg::FRAC_SHIFT+lcsa_pkg::WEIGHT_W-1:lcsa_pkg::FRAC_SHIFT];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (ready_out) begin
			out_q.average <= avg_s3;
			out_q.weight <= weight_out;
			out_q.timed_out <= timed_s3;
			out_q.tare_busy <= busy_s3;
			out_q.tare_captured <= capt_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

// File: bench/load_cell_scale_averager_unit_tb.sv
// Self-checking testbench for the load cell scale averager with random and directed items.
module load_cell_scale_averager_unit_tb;

	localparam logic [lcsa_pkg::KIND_W-1:0] KIND_RESERVED = 2'd3;
	localparam int PHASES = 12;
	localparam int ITEMS_PER_PHASE = 70;
	localparam int DRAIN_CYCLES = 8;
	localparam int QUIET_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [lcsa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [lcsa_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	lcsa_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	lcsa_pkg::out_item_t out_data;

	load_cell_scale_averager_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Scale state as the block should hold it
	logic [lcsa_pkg::SAMPLE_W-1:0] win_samples [lcsa_pkg::WINDOW] = '{default: '0};
	logic [lcsa_pkg::SUM_W-1:0] win_sum = '0;
	logic [lcsa_pkg::IDX_W-1:0] win_pos = '0;
	int tare_seen = 0;
	bit tare_running = 1'b0;
	logic [lcsa_pkg::SAMPLE_W-1:0] tare_offset = '0;
	bit tare_valid = 1'b0;
	logic signed [lcsa_pkg::RECIP_W-1:0] cal_recip = lcsa_pkg::CAL_RECIP_RESET;
	logic [lcsa_pkg::SAMPLE_W-1:0] preset_off = '0;

	lcsa_pkg::in_item_t words_to_send[$];
	lcsa_pkg::out_item_t readings_due[$];

	bit idle_on = 1'b1;
	int send_gap = 0;
	int stall_gap = 0;
	int quiet_cycles = 0;
	int errors = 0;
	int n_checked = 0;
	int n_captures = 0;
	int n_timeouts = 0;
	int n_saturated = 0;
	int n_zero_wt = 0;

	// Weight = (average - zero point) * reciprocal >> 16, floored at zero, saturated high
	function automatic logic [lcsa_pkg::WEIGHT_W-1:0] weight_for(
		logic [lcsa_pkg::SAMPLE_W-1:0] avg);
		longint zero_point;
		longint product;
		zero_point = tare_valid ? longint'(tare_offset) : longint'(preset_off);
		product = (longint'(avg) - zero_point) * longint'(cal_recip);
		if (product <= 0)
			return '0;
		product = product >>> lcsa_pkg::FRAC_SHIFT;
		if (product > 64'sh0000_0000_FFFF_FFFF)
			return '1;
		return product[lcsa_pkg::WEIGHT_W-1:0];
	endfunction

	// Apply one accepted item to the scale state; queue the reading it gives, if any
	function automatic void accept_item(lcsa_pkg::in_item_t it);
		lcsa_pkg::out_item_t r;
		logic [lcsa_pkg::SAMPLE_W-1:0] s;
		r = '0;
		if (it.kind == lcsa_pkg::KIND_TARE) begin
			tare_running = 1'b1;
			tare_seen = 0;
			return;
		end
		if (it.kind == lcsa_pkg::KIND_READ) begin
			if (!it.adc_word[0])
				return;
			s = it.adc_word[lcsa_pkg::WORD_W-1:1];
			win_sum = win_sum - win_samples[win_pos] + s;
			win_samples[win_pos] = s;
			win_pos = (win_pos == lcsa_pkg::IDX_W'(lcsa_pkg::WINDOW - 1))
				? '0 : win_pos + 1'b1;
			r.average = win_sum[lcsa_pkg::SUM_W-1:lcsa_pkg::WIN_LOG];
		end else if (it.kind == lcsa_pkg::KIND_TIMEOUT) begin
			r.timed_out = 1'b1;
		end else begin
			return;
		end
		if (tare_running) begin
			if (tare_seen < lcsa_pkg::TARE_SAMPLES) begin
				tare_seen++;
				r.tare_busy = 1'b1;
			end else begin
				// capture uses the average of this item (zero on a timeout)
				tare_offset = r.average;
				tare_valid = 1'b1;
				tare_running = 1'b0;
				tare_seen = 0;
				r.tare_captured = 1'b1;
			end
		end
		if (!r.timed_out)
			r.weight = weight_for(r.average);
		readings_due.push_back(r);
	endfunction

	function automatic void check_field(string what, longint unsigned want, longint unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
		end
	endfunction

	// Driver: feeds pending items, with random gaps when idling is on
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				accept_item(in_data);
			if (!(in_valid && in_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(0, 8);
					in_valid <= 1'b0;
				end else if (words_to_send.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= words_to_send.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted reading, and stalls the output in random bursts
	always @(posedge clk) begin
		lcsa_pkg::out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (readings_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected reading, expected none, got %0h", $time, out_data);
				end else begin
					want = readings_due.pop_front();
					check_field("average", want.average, out_data.average);
					check_field("weight", want.weight, out_data.weight);
					check_field("timed_out", want.timed_out, out_data.timed_out);
					check_field("tare_busy", want.tare_busy, out_data.tare_busy);
					check_field("tare_captured", want.tare_captured, out_data.tare_captured);
					n_checked++;
					if (want.tare_captured)
						n_captures++;
					if (want.timed_out)
						n_timeouts++;
					if (want.weight == '1)
						n_saturated++;
					if (want.weight == '0 && !want.timed_out)
						n_zero_wt++;
				end
			end
			if (stall_gap > 0) begin
				stall_gap--;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_gap = $urandom_range(0, 8);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
				$display("FAILURE");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic write_reg(logic [lcsa_pkg::CFG_IDX_W-1:0] idx,
		logic [lcsa_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == lcsa_pkg::REG_CAL_RECIP) begin
			cal_recip = val;
		end else begin
			// a new preset drops any captured tare
			preset_off = val[lcsa_pkg::SAMPLE_W-1:0];
			tare_valid = 1'b0;
		end
	endtask

	task automatic write_preset(logic [lcsa_pkg::SAMPLE_W-1:0] val);
		write_reg(lcsa_pkg::REG_PRESET_OFFSET,
			{{(lcsa_pkg::CFG_DATA_W-lcsa_pkg::SAMPLE_W){1'b0}}, val});
	endtask

	// Wait for the block to drain; not-ready words may still be in flight
	task automatic settle();
		while (words_to_send.size() > 0 || in_valid || readings_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void push_word(logic [lcsa_pkg::KIND_W-1:0] kind,
		logic [lcsa_pkg::WORD_W-1:0] adc);
		lcsa_pkg::in_item_t it;
		it.kind = kind;
		it.adc_word = adc;
		words_to_send.push_back(it);
	endfunction

	// Sample values biased toward the extremes and toward the preset offset
	function automatic logic [lcsa_pkg::SAMPLE_W-1:0] pick_sample();
		int lo;
		int hi;
		lo = (int'(preset_off) > 64) ? int'(preset_off) - 64 : 0;
		hi = (int'(preset_off) < 23'h7FFFFF - 64) ? int'(preset_off) + 64 : 23'h7FFFFF;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return lcsa_pkg::SAMPLE_W'($urandom_range(lo, hi));
			4: return lcsa_pkg::SAMPLE_W'($urandom_range(0, 255));
			default: return lcsa_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	// One random item; returns 1 if it changes the scale state
	function automatic int push_random(int tare_pct);
		int roll;
		logic [lcsa_pkg::WORD_W-1:0] adc;
		roll = $urandom_range(0, 99);
		adc = lcsa_pkg::WORD_W'($urandom);
		if (roll < 8) begin
			adc[0] = 1'b0;
			push_word(lcsa_pkg::KIND_READ, adc);
			return 0;
		end
		if (roll < 11) begin
			push_word(KIND_RESERVED, adc);
			return 0;
		end
		if (roll < 19)
			push_word(lcsa_pkg::KIND_TIMEOUT, adc);
		else if (roll < 19 + tare_pct)
			push_word(lcsa_pkg::KIND_TARE, adc);
		else
			push_word(lcsa_pkg::KIND_READ, {pick_sample(), 1'b1});
		return 1;
	endfunction

	// Tare request, full count of samples and timeouts, then the capture item; sometimes restarted midway
	function automatic void push_tare_run();
		int n;
		bit restart;
		restart = ($urandom_range(0, 7) == 0);
		push_word(lcsa_pkg::KIND_TARE, lcsa_pkg::WORD_W'($urandom));
		n = 0;
		while (n < lcsa_pkg::TARE_SAMPLES) begin
			n += push_random(0);
			if (restart && n == lcsa_pkg::TARE_SAMPLES / 2) begin
				push_word(lcsa_pkg::KIND_TARE, lcsa_pkg::WORD_W'($urandom));
				restart = 1'b0;
				n = 0;
			end
		end
		if ($urandom_range(0, 3) == 0)
			push_word(lcsa_pkg::KIND_TIMEOUT, lcsa_pkg::WORD_W'($urandom));
		else
			push_word(lcsa_pkg::KIND_READ, {pick_sample(), 1'b1});
	endfunction

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			idle_on = (ph != PHASES - 1);
			case (ph)
				0: ;
				1: begin
					write_reg(lcsa_pkg::REG_CAL_RECIP, 32'h7FFF_FFFF);
					write_preset('0);
				end
				2: begin
					write_reg(lcsa_pkg::REG_CAL_RECIP, 32'h8000_0000);
					write_preset('1);
				end
				3: write_reg(lcsa_pkg::REG_CAL_RECIP, '0);
				4: begin
					write_reg(lcsa_pkg::REG_CAL_RECIP, 32'hFFFF_FFFF);
					write_preset(lcsa_pkg::SAMPLE_W'($urandom));
				end
				5: write_reg(lcsa_pkg::REG_CAL_RECIP, 32'h0000_0001);
				PHASES - 1: begin
					write_reg(lcsa_pkg::REG_CAL_RECIP, lcsa_pkg::CAL_RECIP_RESET);
					write_preset('0);
				end
				default: begin
					if ($urandom_range(0, 3) == 0)
						write_reg(lcsa_pkg::REG_CAL_RECIP, $urandom);
					else
						write_reg(lcsa_pkg::REG_CAL_RECIP,
							32'($urandom_range(1 << 20, 1 << 26)));
					if ($urandom_range(0, 1) == 0)
						write_preset(lcsa_pkg::SAMPLE_W'($urandom));
				end
			endcase

			if (ph == 0) begin
				// field extremes, every kind, and the ignored cases
				push_word(lcsa_pkg::KIND_READ, 24'h00_0001);
				push_word(lcsa_pkg::KIND_READ, 24'hFF_FFFF);
				push_word(lcsa_pkg::KIND_READ, 24'hFF_FFFE);
				push_word(lcsa_pkg::KIND_READ, 24'h00_0000);
				push_word(lcsa_pkg::KIND_TIMEOUT, 24'hFF_FFFF);
				push_word(lcsa_pkg::KIND_TIMEOUT, 24'h00_0000);
				push_word(KIND_RESERVED, 24'hFF_FFFF);
				push_word(KIND_RESERVED, 24'h00_0001);
				push_word(lcsa_pkg::KIND_READ, 24'hAA_AAAB);
				push_word(lcsa_pkg::KIND_READ, 24'h55_5555);
				push_word(lcsa_pkg::KIND_READ, 24'hFF_FFFF);
				// tare, then a restart while it runs
				push_word(lcsa_pkg::KIND_TARE, 24'h00_0000);
				push_word(lcsa_pkg::KIND_READ, 24'h80_0001);
				push_word(lcsa_pkg::KIND_TIMEOUT, 24'h12_3456);
				push_word(lcsa_pkg::KIND_TARE, 24'hFF_FFFF);
				push_word(lcsa_pkg::KIND_READ, 24'h00_0003);
				push_word(lcsa_pkg::KIND_READ, 24'h7F_FFFF);
			end

			// fill the pending list for this phase; a tare run may go a little past it
			while (words_to_send.size() < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 14) == 0)
					push_tare_run();
				else
					void'(push_random(4));
			end
			settle();
		end

		$display("checked %0d readings over %0d register settings: %0d timeouts, %0d tare captures",
			n_checked, PHASES, n_timeouts, n_captures);
		$display("weights saturated high %0d times, clamped to zero %0d times",
			n_saturated, n_zero_wt);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
